@@ design/gaussian_blur_3x3_stream_macros.svh @@
// Assertion macros shared by the blur stream RTL.
// Needs no other file; included by files that carry concurrent checks.
`ifndef GAUSSIAN_BLUR_3X3_STREAM_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gbs_pkg.sv @@
// Package for the 3x3 Gaussian blur stream: widths, types, register codes.
// No dependencies; imported by the interfaces, the kernel and the top module.
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int DIM_BITS     = 11;
  localparam int SUM_BITS     = PIXEL_BITS + 4;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam dim_t WIDTH_RESET  = DIM_BITS'(640);
  localparam dim_t HEIGHT_RESET = DIM_BITS'(480);
  localparam dim_t DIM_MIN      = DIM_BITS'(3);
  localparam dim_t WIDTH_MAX    = DIM_BITS'(MAX_WIDTH);
  localparam dim_t HEIGHT_MAX   = DIM_BITS'(HEIGHT_LIMIT);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = CFG_IDX_BITS'(0),
    CFG_IMAGE_HEIGHT = CFG_IDX_BITS'(1)
  } cfg_idx_e;

  // 3x3 neighbourhood, t/m/b rows and l/m/r columns
  typedef struct packed {
    pixel_t tl, tm, tr;
    pixel_t ml, mm, mr;
    pixel_t bl, bm, br;
  } win_t;

  // Clamp a programmed dimension to the supported range
  function automatic dim_t clamp_dim(dim_t v, dim_t hi);
    dim_t r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/gbs_if.sv @@
// Stream and configuration interfaces of the blur block.
// Depends on gbs_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

// Input pixel beats
interface gbs_pix_in_if;
  import gbs_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// Filtered result beats
interface gbs_pix_out_if;
  import gbs_pkg::*;
  logic   valid;
  logic   ready;
  row_t   out_row;
  col_t   out_col;
  pixel_t pixel_out;
  logic   frame_last;
  modport source (output valid, output out_row, output out_col, output pixel_out,
                  output frame_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input pixel_out,
                  input frame_last, output ready);
endinterface

// Register write beats
interface gbs_cfg_if;
  import gbs_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/gbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/gbs_kernel.sv @@
// 1-2-1 x 1-2-1 weighted sum of a 3x3 window, divided by 16.
// Depends on gbs_pkg for win_t and the pixel widths.
`timescale 1ns / 1ps
`default_nettype none

module gbs_kernel (
  input  wire gbs_pkg::win_t   win_i,
  output gbs_pkg::pixel_t      pixel_o
);

  import gbs_pkg::*;

  logic [SUM_BITS-1:0] corner_sum;
  logic [SUM_BITS-1:0] edge_sum;
  logic [SUM_BITS-1:0] total_sum;

  // Corners weigh 1, edges 2, centre 4
  assign corner_sum = SUM_BITS'(win_i.tl) + SUM_BITS'(win_i.tr)
                    + SUM_BITS'(win_i.bl) + SUM_BITS'(win_i.br);
  assign edge_sum   = SUM_BITS'(win_i.tm) + SUM_BITS'(win_i.ml)
                    + SUM_BITS'(win_i.mr) + SUM_BITS'(win_i.bm);
  assign total_sum  = corner_sum + (edge_sum << 1) + (SUM_BITS'(win_i.mm) << 2);

  // Divide by 16, truncating
  assign pixel_o = total_sum[SUM_BITS-1:4];

endmodule

`default_nettype wire

@@ design/gaussian_blur_3x3_stream.sv @@
// 3x3 Gaussian blur over a raster-order 8-bit pixel stream.
// Usage:
//   pix_in_i  : one pixel per beat, raster order, row by row.
//   pix_out_o : one beat per interior pixel with its row, column, blurred
//               value and a flag on the final interior pixel of the frame.
//               Border pixels give no beat.
//   cfg_i     : index 0 writes the image width, index 1 the height (both
//               clamped to 3..1024). Any write to these restarts the frame.
//               Write only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver takes results; the two line buffers are
//   single-write single-read RAMs addressed by the column counter, so no
//   port is shared between read and write.
// Path: an accepted beat is registered in the read stage, then its result in
//   the output register, where it is held until taken.
// Reset: width 640, height 480, counters and window cleared; line buffer
//   contents are undefined and only used after being written.
// Stall: the output register plus the read stage absorb a stalled receiver;
//   input ready drops only when both are full.
// Depends on gbs_pkg, gbs_if, gbs_ram, gbs_kernel and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_blur_3x3_stream_macros.svh"

module gaussian_blur_3x3_stream (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gbs_pix_in_if.sink  pix_in_i,
  gbs_pix_out_if.source pix_out_o,
  gbs_cfg_if.sink     cfg_i
);

  import gbs_pkg::*;

  // Configuration registers
  dim_t width_q, height_q;
  dim_t eff_w, eff_h;
  logic cfg_hit;

  // Input side counters
  col_t col_q;
  row_t row_q;
  dim_t col_inc, row_inc;
  logic in_accept;

  // Read stage
  logic   s1_valid_q;
  pixel_t s1_pixel_q;
  col_t   s1_col_q;
  row_t   s1_row_q;
  logic   s1_emit;
  logic   s1_fire;
  pixel_t top_pix, mid_pix;

  // Window of the two previous columns
  pixel_t win_q [6];
  win_t   win;
  pixel_t blurred;

  // Output register
  logic   out_valid_q;
  row_t   out_row_q;
  col_t   out_col_q;
  pixel_t out_pixel_q;
  logic   out_last_q;
  logic   out_free;

  // Register writes
  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid
                && (cfg_i.index == CFG_IMAGE_WIDTH || cfg_i.index == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_i.data;
      end
      if (cfg_i.index == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  assign eff_w = clamp_dim(width_q, WIDTH_MAX);
  assign eff_h = clamp_dim(height_q, HEIGHT_MAX);

  // Handshake
  assign out_free       = !out_valid_q || pix_out_o.ready;
  assign s1_emit        = (s1_row_q >= ROW_BITS'(2)) && (s1_col_q >= COL_BITS'(2));
  assign s1_fire        = s1_valid_q && (!s1_emit || out_free);
  assign pix_in_i.ready = !s1_valid_q || s1_fire;
  assign in_accept      = pix_in_i.valid && pix_in_i.ready;

  // Position of the incoming pixel
  assign col_inc = DIM_BITS'(col_q) + DIM_BITS'(1);
  assign row_inc = DIM_BITS'(row_q) + DIM_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      if (col_inc >= eff_w) begin
        col_q <= '0;
        row_q <= (row_inc >= eff_h) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col_q <= col_inc[COL_BITS-1:0];
      end
    end
  end

  // Line buffers: a holds the previous row, b the one before
  gbs_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pixel_q),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (mid_pix)
  );

  gbs_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (mid_pix),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (top_pix)
  );

  // Read stage: pixel waits here while its column is read out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pix_in_i.pixel_in;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
    end
  end

  // Window shift as each beat leaves the read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_hit) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      win_q[0] <= win_q[1];
      win_q[1] <= top_pix;
      win_q[2] <= win_q[3];
      win_q[3] <= mid_pix;
      win_q[4] <= win_q[5];
      win_q[5] <= s1_pixel_q;
    end
  end

  assign win = '{tl: win_q[0], tm: win_q[1], tr: top_pix,
                 ml: win_q[2], mm: win_q[3], mr: mid_pix,
                 bl: win_q[4], bm: win_q[5], br: s1_pixel_q};

  gbs_kernel u_kernel (
    .win_i   (win),
    .pixel_o (blurred)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (pix_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      out_row_q   <= s1_row_q - ROW_BITS'(1);
      out_col_q   <= s1_col_q - COL_BITS'(1);
      out_pixel_q <= blurred;
      out_last_q  <= (DIM_BITS'(s1_row_q) + DIM_BITS'(1) == eff_h)
                  && (DIM_BITS'(s1_col_q) + DIM_BITS'(1) == eff_w);
    end
  end

  assign pix_out_o.valid      = out_valid_q;
  assign pix_out_o.out_row    = out_row_q;
  assign pix_out_o.out_col    = out_col_q;
  assign pix_out_o.pixel_out  = out_pixel_q;
  assign pix_out_o.frame_last = out_last_q;

  // Checks
  `GBS_ASSERT_NOW(a_col_in_range, clk_i, rst_ni, 1'b1, DIM_BITS'(col_q) < eff_w,
                  "column counter beyond image width")
  `GBS_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, s1_valid_q && !s1_fire && !in_accept,
                   s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q),
                   "stalled read stage lost its beat")
  `GBS_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni, s1_fire && s1_emit, out_valid_q,
                   "interior pixel not placed in output register")
  `GBS_ASSERT_NOW(a_no_overrun, clk_i, rst_ni, s1_fire && s1_emit && out_valid_q,
                  pix_out_o.ready, "output register overwritten while full")

endmodule

`default_nettype wire
